// ===== sv/rvy_pkg.sv =====
// Shared widths, sideband types and the CORDIC angle table for the
// rotation-vector-to-yaw pipeline. No dependencies.
package rvy_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int YAW_FRAC_BITS  = 12;

    localparam int HALF_W   = 16;
    localparam int MAG_W    = 41;              // decoded magnitude, units of 2^-24
    localparam int A_W      = 31;              // magnitude after common down-shift
    localparam int K_W      = 4;               // down-shift amount, 0..10
    localparam int SQ_W     = 2 * A_W;
    localparam int RAD_W    = 64;              // square-root operand
    localparam int ROOT_W   = 32;
    localparam int DEN_W    = ROOT_W + 1;
    localparam int NUM_W    = A_W + QUAT_FRAC_BITS + 2;
    localparam int QU_W     = QUAT_FRAC_BITS + 1;
    localparam int Q_W      = 16;
    localparam int W_W      = 15;
    localparam int YAW_W    = 15;
    localparam int P_W      = 32;              // quaternion products
    localparam int C_W      = 36;              // CORDIC x and y
    localparam int ANG_W    = 64;              // angle, Q60

    localparam int SQRT_STEPS   = RAD_W / 2;
    localparam int DIV_STEPS    = QUAT_FRAC_BITS + 1;
    localparam int CORDIC_STEPS = 32;

    localparam int UNSC_SH  = 24 - QUAT_FRAC_BITS;
    localparam int RAD_SH   = 46 - 2 * QUAT_FRAC_BITS;
    localparam int ANG_SH   = 60 - YAW_FRAC_BITS;

    localparam logic [4:0]       EXP_SPECIAL = 5'h1F;
    localparam logic [RAD_W-1:0] ONE_SQ      = RAD_W'(1) << 48;
    localparam logic [QU_W-1:0]  Q_LIM       = QU_W'(1) << QUAT_FRAC_BITS;

    typedef struct packed {
        logic                      bad;
        logic                      scaled;
        logic [2:0]                neg;
        logic [2:0][A_W-1:0]       a;
        logic [2:0][QU_W-1:0]      qu;
    } side_t;

    typedef struct packed {
        logic                      bad;
        logic                      scaled;
        logic [2:0][Q_W-1:0]       q;
        logic [W_W-1:0]            w;
    } quat_t;

    typedef logic [CORDIC_STEPS-1:0][ANG_W-1:0] ang_tab_t;

    // atan(2^-i) in Q60 by the alternating series, i >= 1
    function automatic logic [ANG_W-1:0] atan_pow2(input int i);
        logic [ANG_W-1:0] p;
        logic [ANG_W-1:0] acc;
        logic [ANG_W-1:0] term;
        p   = ANG_W'(1) << (60 - i);
        acc = '0;
        for (int k = 0; k < 40; k++)
        begin
            term = p / ANG_W'(2 * k + 1);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
            p = p >> (2 * i);
        end
        return acc;
    endfunction

    // atan(1/3) in Q60
    function automatic logic [ANG_W-1:0] atan_third();
        logic [ANG_W-1:0] p;
        logic [ANG_W-1:0] acc;
        logic [ANG_W-1:0] term;
        p   = (ANG_W'(1) << 60) / 64'd3;
        acc = '0;
        for (int k = 0; k < 40; k++)
        begin
            term = p / ANG_W'(2 * k + 1);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
            p = p / 64'd9;
        end
        return acc;
    endfunction

    localparam logic [ANG_W-1:0] QUARTER_PI = atan_pow2(1) + atan_third();
    localparam logic [ANG_W-1:0] HALF_PI    = QUARTER_PI << 1;
    localparam logic [ANG_W-1:0] PI_Q60     = QUARTER_PI << 2;
    localparam logic [YAW_W:0]   YAW_LIM    =
        (YAW_W + 1)'((PI_Q60 + (ANG_W'(1) << (ANG_SH - 1))) >> ANG_SH);

    function automatic ang_tab_t build_ang_tab();
        ang_tab_t t;
        t[0] = QUARTER_PI;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            t[i] = atan_pow2(i);
        end
        return t;
    endfunction

    localparam ang_tab_t ANG_TAB = build_ang_tab();

endpackage

// ===== sv/rvy_front.sv =====
// Front end: half-precision decode, common down-shift, squares and the
// square-root operand. Depends on rvy_pkg.
module rvy_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0][15:0]              halves,
    output logic                          out_valid,
    output rvy_pkg::side_t                side,
    output logic [rvy_pkg::RAD_W-1:0]     rad
);
    import rvy_pkg::*;

    logic [3:0]               v_reg;
    logic [2:0][MAG_W-1:0]    mag_reg, mag_next;
    logic [2:0]               neg0_reg, neg1_reg, neg2_reg;
    logic                     bad0_reg, bad1_reg, bad2_reg, bad0_next;
    logic [2:0][A_W-1:0]      a1_reg, a1_next, a2_reg;
    logic [2:0][QU_W-1:0]     qu1_reg, qu1_next, qu2_reg;
    logic [2:0][SQ_W-1:0]     sq_reg, sq_next;
    side_t                    side_reg, side_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;

    logic [MAG_W-1:0]         orm;
    logic [K_W-1:0]           k;
    logic [RAD_W-1:0]         ssum, diff;
    logic [25:0]              qsum;

    // decode
    always_comb
    begin
        bad0_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (halves[i][14:10] == 5'd0)
                mag_next[i] = MAG_W'(halves[i][9:0]);
            else
                mag_next[i] = MAG_W'({1'b1, halves[i][9:0]}) << (halves[i][14:10] - 5'd1);
            if (halves[i][14:10] == EXP_SPECIAL)
                bad0_next = 1'b1;
        end
    end

    // common shift and unscaled rounding
    always_comb
    begin
        orm = mag_reg[0] | mag_reg[1] | mag_reg[2];
        k   = '0;
        for (int j = 0; j < MAG_W - A_W; j++)
        begin
            if (orm[A_W + j])
                k = K_W'(j + 1);
        end
        for (int i = 0; i < 3; i++)
        begin
            a1_next[i] = A_W'(mag_reg[i] >> k);
            qsum       = {1'b0, mag_reg[i][24:0]} + (26'd1 << (UNSC_SH - 1));
            if (qsum[25:UNSC_SH] > {1'b0, Q_LIM})
                qu1_next[i] = Q_LIM;
            else
                qu1_next[i] = qsum[UNSC_SH+QU_W-1:UNSC_SH];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQ_W'(a1_reg[i]) * SQ_W'(a1_reg[i]);
        end
    end

    always_comb
    begin
        ssum = RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
        diff = ONE_SQ - ssum;
        side_next.bad    = bad2_reg;
        side_next.scaled = ssum > ONE_SQ;
        side_next.neg    = neg2_reg;
        side_next.a      = a2_reg;
        side_next.qu     = qu2_reg;
        rad_next = side_next.scaled ? ssum : (diff >> RAD_SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next;
            neg0_reg <= {halves[2][15], halves[1][15], halves[0][15]};
            bad0_reg <= bad0_next;
            a1_reg   <= a1_next;
            qu1_reg  <= qu1_next;
            neg1_reg <= neg0_reg;
            bad1_reg <= bad0_reg;
            sq_reg   <= sq_next;
            a2_reg   <= a1_reg;
            qu2_reg  <= qu1_reg;
            neg2_reg <= neg1_reg;
            bad2_reg <= bad1_reg;
            side_reg <= side_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = v_reg[3];
    assign side      = side_reg;
    assign rad       = rad_reg;

endmodule

// ===== sv/rvy_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with the
// sample's sideband carried alongside. Depends on rvy_pkg.
module rvy_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rvy_pkg::side_t                in_side,
    input  logic [rvy_pkg::RAD_W-1:0]     rad,
    output logic                          out_valid,
    output rvy_pkg::side_t                out_side,
    output logic [rvy_pkg::ROOT_W-1:0]    root
);
    import rvy_pkg::*;

    logic [SQRT_STEPS-1:0] v_reg;
    logic [RAD_W-1:0]      n_reg   [SQRT_STEPS];
    logic [RAD_W-1:0]      res_reg [SQRT_STEPS];
    side_t                 side_reg [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [RAD_W-1:0] n_in, r_in, bit_c, trial, n_next, res_next;
        logic             v_in;
        side_t            s_in;

        if (j == 0)
        begin : g_first
            assign n_in = rad;
            assign r_in = '0;
            assign v_in = in_valid;
            assign s_in = in_side;
        end
        else
        begin : g_rest
            assign n_in = n_reg[j-1];
            assign r_in = res_reg[j-1];
            assign v_in = v_reg[j-1];
            assign s_in = side_reg[j-1];
        end

        assign bit_c = RAD_W'(1) << (RAD_W - 2 - 2 * j);
        assign trial = r_in + bit_c;

        always_comb
        begin
            if (n_in >= trial)
            begin
                n_next   = n_in - trial;
                res_next = (r_in >> 1) + bit_c;
            end
            else
            begin
                n_next   = n_in;
                res_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[j]    <= n_next;
                res_reg[j]  <= res_next;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== sv/rvy_div.sv =====
// Normalisation: w from the root, three restoring dividers (one quotient
// bit per stage) and the final sign and clamp. Depends on rvy_pkg.
module rvy_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rvy_pkg::side_t                in_side,
    input  logic [rvy_pkg::ROOT_W-1:0]    root,
    output logic                          out_valid,
    output rvy_pkg::quat_t                quat
);
    import rvy_pkg::*;

    logic                  v0_reg;
    logic [DEN_W-1:0]      d0_reg, d0_next;
    logic [2:0][NUM_W-1:0] num0_reg, num0_next;
    logic [W_W-1:0]        w0_reg, w0_next;
    side_t                 side0_reg;

    logic [DIV_STEPS-1:0]  v_reg;
    logic [DEN_W-1:0]      d_reg    [DIV_STEPS];
    logic [2:0][NUM_W-1:0] rem_reg  [DIV_STEPS];
    logic [2:0][QU_W-1:0]  quo_reg  [DIV_STEPS];
    logic [W_W-1:0]        w_reg    [DIV_STEPS];
    side_t                 side_reg [DIV_STEPS];

    logic                  vq_reg;
    quat_t                 quat_reg, quat_next;

    logic [ROOT_W-1:0]     r_nz;
    logic [ROOT_W:0]       r_p1;

    always_comb
    begin
        r_nz    = (root == '0) ? ROOT_W'(1) : root;
        d0_next = {r_nz, 1'b0};
        r_p1    = {1'b0, root} + (ROOT_W + 1)'(1);
        for (int i = 0; i < 3; i++)
        begin
            num0_next[i] = (NUM_W'(in_side.a[i]) << (QUAT_FRAC_BITS + 1)) + NUM_W'(r_nz);
        end
        if (in_side.scaled)
            w0_next = '0;
        else if (r_p1[ROOT_W:1] > ROOT_W'(Q_LIM))
            w0_next = W_W'(Q_LIM);
        else
            w0_next = W_W'(r_p1[ROOT_W:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg    <= d0_next;
            num0_reg  <= num0_next;
            w0_reg    <= w0_next;
            side0_reg <= in_side;
        end
    end

    for (genvar t = 0; t < DIV_STEPS; t++)
    begin : g_step
        logic                  v_in;
        logic [DEN_W-1:0]      d_in;
        logic [2:0][NUM_W-1:0] rem_in, rem_next;
        logic [2:0][QU_W-1:0]  quo_in, quo_next;
        logic [W_W-1:0]        w_in;
        side_t                 s_in;
        logic [NUM_W-1:0]      dsh;

        if (t == 0)
        begin : g_first
            assign v_in   = v0_reg;
            assign d_in   = d0_reg;
            assign rem_in = num0_reg;
            assign quo_in = '0;
            assign w_in   = w0_reg;
            assign s_in   = side0_reg;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[t-1];
            assign d_in   = d_reg[t-1];
            assign rem_in = rem_reg[t-1];
            assign quo_in = quo_reg[t-1];
            assign w_in   = w_reg[t-1];
            assign s_in   = side_reg[t-1];
        end

        assign dsh = NUM_W'(d_in) << (DIV_STEPS - 1 - t);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= dsh)
                begin
                    rem_next[i] = rem_in[i] - dsh;
                    quo_next[i] = {quo_in[i][QU_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = {quo_in[i][QU_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[t] <= 1'b0;
            else if (en)
                v_reg[t] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[t]    <= d_in;
                rem_reg[t]  <= rem_next;
                quo_reg[t]  <= quo_next;
                w_reg[t]    <= w_in;
                side_reg[t] <= s_in;
            end
        end
    end

    // pick the scaled or unscaled magnitude, clamp, restore the sign
    always_comb
    begin
        logic [QU_W-1:0] vq;
        logic [QU_W-1:0] mq;
        quat_next.bad    = side_reg[DIV_STEPS-1].bad;
        quat_next.scaled = side_reg[DIV_STEPS-1].scaled;
        quat_next.w      = w_reg[DIV_STEPS-1];
        for (int i = 0; i < 3; i++)
        begin
            vq = quo_reg[DIV_STEPS-1][i];
            if (vq > Q_LIM)
                vq = Q_LIM;
            mq = side_reg[DIV_STEPS-1].scaled ? vq : side_reg[DIV_STEPS-1].qu[i];
            if (side_reg[DIV_STEPS-1].neg[i])
                quat_next.q[i] = Q_W'(0) - Q_W'(mq);
            else
                quat_next.q[i] = Q_W'(mq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= 1'b0;
        else if (en)
            vq_reg <= v_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quat_reg <= quat_next;
    end

    assign out_valid = vq_reg;
    assign quat      = quat_reg;

endmodule

// ===== sv/rvy_yaw.sv =====
// Yaw: atan2 arguments from the quaternion, quadrant fold, a 32-stage
// vectoring CORDIC and the final rounding. Depends on rvy_pkg.
module rvy_yaw (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rvy_pkg::quat_t                in_quat,
    output logic                          out_valid,
    output rvy_pkg::quat_t                out_quat,
    output logic [rvy_pkg::YAW_W-1:0]     yaw
);
    import rvy_pkg::*;

    logic [2:0]              vh_reg;
    quat_t                   qh_reg [3];
    logic signed [P_W-1:0]   pwz_reg, pxy_reg, pyy_reg, pzz_reg;
    logic signed [C_W-1:0]   s1_reg, s2_reg, s1_next, s2_next;
    logic signed [C_W-1:0]   x0_reg, y0_reg, x0_next, y0_next;
    logic signed [ANG_W-1:0] z0_reg, z0_next;
    logic                    zero0_reg;
    logic signed [P_W-1:0]   ew, ex, ey, ez;

    logic [CORDIC_STEPS-1:0] v_reg;
    logic signed [C_W-1:0]   cx_reg [CORDIC_STEPS];
    logic signed [C_W-1:0]   cy_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] cz_reg [CORDIC_STEPS];
    logic                    zero_reg [CORDIC_STEPS];
    quat_t                   q_reg    [CORDIC_STEPS];

    logic                    vo_reg;
    quat_t                   qo_reg;
    logic [YAW_W-1:0]        yaw_reg, yaw_next;

    always_comb
    begin
        ew = P_W'(in_quat.w);
        ex = {{(P_W-Q_W){in_quat.q[0][Q_W-1]}}, in_quat.q[0]};
        ey = {{(P_W-Q_W){in_quat.q[1][Q_W-1]}}, in_quat.q[1]};
        ez = {{(P_W-Q_W){in_quat.q[2][Q_W-1]}}, in_quat.q[2]};
    end

    always_comb
    begin
        s1_next = (C_W'(pwz_reg) + C_W'(pxy_reg)) <<< 1;
        s2_next = (C_W'(1) << (2 * QUAT_FRAC_BITS)) - ((C_W'(pyy_reg) + C_W'(pzz_reg)) <<< 1);
    end

    // fold a negative x into the right half plane
    always_comb
    begin
        x0_next = s2_reg;
        y0_next = s1_reg;
        z0_next = '0;
        if (s2_reg < 0)
        begin
            if (s1_reg >= 0)
            begin
                x0_next = s1_reg;
                y0_next = -s2_reg;
                z0_next = HALF_PI;
            end
            else
            begin
                x0_next = -s1_reg;
                y0_next = s2_reg;
                z0_next = -$signed(HALF_PI);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vh_reg <= '0;
        else if (en)
            vh_reg <= {vh_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qh_reg[0] <= in_quat;
            pwz_reg   <= ew * ez;
            pxy_reg   <= ex * ey;
            pyy_reg   <= ey * ey;
            pzz_reg   <= ez * ez;
            qh_reg[1] <= qh_reg[0];
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            qh_reg[2] <= qh_reg[1];
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= z0_next;
            zero0_reg <= (s1_reg == '0) && (s2_reg == '0);
        end
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_step
        logic                    v_in, zero_in;
        logic signed [C_W-1:0]   x_in, y_in, dx, dy, x_next, y_next;
        logic signed [ANG_W-1:0] z_in, z_next;
        quat_t                   q_in;

        if (j == 0)
        begin : g_first
            assign v_in    = vh_reg[2];
            assign x_in    = x0_reg;
            assign y_in    = y0_reg;
            assign z_in    = z0_reg;
            assign zero_in = zero0_reg;
            assign q_in    = qh_reg[2];
        end
        else
        begin : g_rest
            assign v_in    = v_reg[j-1];
            assign x_in    = cx_reg[j-1];
            assign y_in    = cy_reg[j-1];
            assign z_in    = cz_reg[j-1];
            assign zero_in = zero_reg[j-1];
            assign q_in    = q_reg[j-1];
        end

        assign dx = y_in >>> j;
        assign dy = x_in >>> j;

        always_comb
        begin
            if (y_in >= 0)
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + $signed(ANG_TAB[j]);
            end
            else
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - $signed(ANG_TAB[j]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[j]   <= x_next;
                cy_reg[j]   <= y_next;
                cz_reg[j]   <= z_next;
                zero_reg[j] <= zero_in;
                q_reg[j]    <= q_in;
            end
        end
    end

    // round the Q60 angle to nearest, ties away from zero, then clamp to pi
    always_comb
    begin
        logic signed [ANG_W-1:0] zf;
        logic [ANG_W-1:0]        za;
        logic [YAW_W:0]          m;
        zf = cz_reg[CORDIC_STEPS-1];
        za = zf[ANG_W-1] ? (ANG_W'(0) - ANG_W'(zf)) : ANG_W'(zf);
        m  = (YAW_W + 1)'((za + (ANG_W'(1) << (ANG_SH - 1))) >> ANG_SH);
        if (m > YAW_LIM)
            m = YAW_LIM;
        if (zero_reg[CORDIC_STEPS-1])
            yaw_next = '0;
        else if (zf[ANG_W-1])
            yaw_next = YAW_W'(0) - m[YAW_W-1:0];
        else
            yaw_next = m[YAW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qo_reg  <= q_reg[CORDIC_STEPS-1];
            yaw_reg <= yaw_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_quat  = qo_reg;
    assign yaw       = yaw_reg;

endmodule

// ===== sv/rotation_vector_to_yaw_core.sv =====
// Top level of the rotation-vector-to-yaw pipeline: stream ports, stall
// control and the output register. Depends on rvy_pkg and the rvy_* stages.
//
//  channel | dir | beat content
//  --------+-----+-------------------------------------------------------------
//  s_*     | in  | tdata: x_half, y_half, z_half (16 bits each)
//  m_*     | out | tdata: quat_x, quat_y, quat_z, quat_w, yaw_angle;
//          |     | tuser: was_scaled, invalid
//
// One beat enters per cycle unless a finished beat is held; the pipe has
// 4 decode/square, 32 square-root, 17 divide/clamp, 36 yaw/CORDIC, 1 out stages.
// The depth is set by the one-bit-per-stage square root and the 32 CORDIC
// stages. Reset (rst_n low, asynchronous) clears every valid bit only.
// Every stage advances together whenever the output register is empty or is
// being taken; otherwise all stages hold, so no beat is dropped or repeated.
module rotation_vector_to_yaw_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_half, y_half, z_half
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // quat_x, quat_y, quat_z, quat_w, yaw_angle, zero pad
    output logic [1:0]  m_tuser    // was_scaled, invalid
);
    import rvy_pkg::*;

    logic                en;
    logic                fr_valid, sq_valid, dv_valid, yw_valid;
    side_t               fr_side, sq_side;
    logic [RAD_W-1:0]    fr_rad;
    logic [ROOT_W-1:0]   sq_root;
    quat_t               dv_quat, yw_quat;
    logic [YAW_W-1:0]    yw_yaw;
    logic [2:0][15:0]    halves;

    logic                m_valid_reg, m_valid_next;
    logic [79:0]         m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;

    // advance the whole pipe unless a finished beat is waiting
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign halves = {s_tdata[47:32], s_tdata[31:16], s_tdata[15:0]};

    rvy_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .halves    (halves),
        .out_valid (fr_valid),
        .side      (fr_side),
        .rad       (fr_rad)
    );

    rvy_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .rad       (fr_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (sq_root)
    );

    rvy_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .root      (sq_root),
        .out_valid (dv_valid),
        .quat      (dv_quat)
    );

    rvy_yaw u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_quat   (dv_quat),
        .out_valid (yw_valid),
        .out_quat  (yw_quat),
        .yaw       (yw_yaw)
    );

    // pack the result; an infinite or NaN input zeroes everything but the flag
    always_comb
    begin
        m_valid_next = yw_valid;
        if (yw_quat.bad)
        begin
            m_data_next = '0;
            m_user_next = 2'b10;
        end
        else
        begin
            m_data_next = {2'b00, yw_yaw, yw_quat.w,
                           yw_quat.q[2], yw_quat.q[1], yw_quat.q[0]};
            m_user_next = {1'b0, yw_quat.scaled};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== tb/tb_rvy_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for rotation_vector_to_yaw_core: watches both stream channels, predicts each
// result from the accepted input beat and compares it field by field. Depends on rvy_pkg.
module tb_rvy_checker
    import rvy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [14:0] qw;
        logic [14:0] yaw;
        logic        scaled;
        logic        bad;
    } pose_t;

    pose_t          pose_q[$];
    longint         atan_q60[32];
    longint         quarter_q60;
    int             errors = 0;

    assign fail_count = errors;
    assign pending    = pose_q.size();

    function automatic longint unsigned sqrt_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // atan(1/n) in Q60 by the alternating series
    function automatic longint atan_recip(input longint unsigned n);
        longint unsigned p;
        longint unsigned n2;
        longint          acc;
        longint unsigned k;
        p   = (64'd1 << 60) / n;
        n2  = n * n;
        acc = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0])
                acc = acc - longint'(p / (2 * k + 1));
            else
                acc = acc + longint'(p / (2 * k + 1));
            p = p / n2;
            k++;
        end
        return acc;
    endfunction

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint to_yaw(input longint z);
        longint m;
        m = (mag64(z) + (64'sd1 <<< 47)) >>> 48;
        return (z < 0) ? -m : m;
    endfunction

    function automatic longint yaw_from(input longint s1, input longint s2);
        longint          xc;
        longint          yc;
        longint          zc;
        longint          t;
        longint          dx;
        longint          dy;
        longint          lim;
        longint unsigned m;
        int              k;
        if (s1 == 0 && s2 == 0)
            return 0;
        m = (mag64(s1) > mag64(s2)) ? mag64(s1) : mag64(s2);
        k = 0;
        while ((m >> k) >= (64'd1 << 59))
            k++;
        xc = s2 >>> k;
        yc = s1 >>> k;
        zc = 0;
        // pre-rotate into the right half-plane
        if (xc < 0)
        begin
            t = xc;
            if (yc >= 0)
            begin
                xc = yc;
                yc = -t;
                zc = 2 * quarter_q60;
            end
            else
            begin
                xc = -yc;
                yc = t;
                zc = -2 * quarter_q60;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            dx = yc >>> i;
            dy = xc >>> i;
            if (yc >= 0)
            begin
                xc = xc + dx;
                yc = yc - dy;
                zc = zc + atan_q60[i];
            end
            else
            begin
                xc = xc - dx;
                yc = yc + dy;
                zc = zc - atan_q60[i];
            end
        end
        zc  = to_yaw(zc);
        lim = to_yaw(4 * quarter_q60);
        if (zc > lim)
            zc = lim;
        if (zc < -lim)
            zc = -lim;
        return zc;
    endfunction

    function automatic pose_t pose_of(input logic [47:0] words);
        pose_t           r;
        longint unsigned mag[3];
        longint unsigned a[3];
        longint unsigned maxm;
        longint unsigned s;
        longint unsigned rt;
        longint unsigned v;
        longint          q[3];
        longint          w;
        logic [15:0]     h;
        logic            neg[3];
        logic            bad;
        logic            scaled;
        int              k;
        r    = '{default: '0};
        maxm = 0;
        bad  = 1'b0;
        w    = 0;
        for (int i = 0; i < 3; i++)
        begin
            h      = words[16*i +: 16];
            neg[i] = h[15];
            if (h[14:10] == EXP_SPECIAL)
                bad = 1'b1;
            if (h[14:10] == 5'd0)
                mag[i] = h[9:0];
            else
                mag[i] = longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
            if (mag[i] > maxm)
                maxm = mag[i];
        end
        if (bad)
        begin
            r.bad = 1'b1;
            return r;
        end
        scaled = 1'b1;
        if (maxm <= (64'd1 << 24))
        begin
            s      = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            scaled = s > (64'd1 << 48);
            if (!scaled)
            begin
                w = longint'((sqrt_floor(((64'd1 << 48) - s) >> 18) + 1) >> 1);
                if (w > 16384)
                    w = 16384;
                for (int i = 0; i < 3; i++)
                begin
                    v = (mag[i] + (64'd1 << 9)) >> 10;
                    if (v > 16384)
                        v = 16384;
                    q[i] = neg[i] ? -longint'(v) : longint'(v);
                end
            end
        end
        if (scaled)
        begin
            // bring the largest magnitude below 2^31, then divide by the length
            k = 0;
            while ((maxm >> k) >= (64'd1 << 31))
                k++;
            for (int i = 0; i < 3; i++)
                a[i] = mag[i] >> k;
            rt = sqrt_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
            if (rt == 0)
                rt = 1;
            for (int i = 0; i < 3; i++)
            begin
                v = ((a[i] << 14) * 2 + rt) / (2 * rt);
                if (v > 16384)
                    v = 16384;
                q[i] = neg[i] ? -longint'(v) : longint'(v);
            end
            w = 0;
        end
        r.yaw    = 15'(yaw_from(2 * (w * q[2] + q[0] * q[1]),
                                (64'sd1 <<< 28) - 2 * (q[1] * q[1] + q[2] * q[2])));
        r.qx     = 16'(q[0]);
        r.qy     = 16'(q[1]);
        r.qz     = 16'(q[2]);
        r.qw     = 15'(w);
        r.scaled = scaled;
        return r;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        quarter_q60 = atan_recip(2) + atan_recip(3);
        atan_q60[0] = quarter_q60;
        for (int i = 1; i < 32; i++)
            atan_q60[i] = atan_recip(64'd1 << i);
    end

    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pose_q.push_back(pose_of(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (pose_q.size() == 0)
                    report("unexpected beat", m_tdata[15:0], 16'h0);
                else
                begin
                    want = pose_q.pop_front();
                    if (m_tdata[15:0] !== want.qx)
                        report("quat_x", m_tdata[15:0], want.qx);
                    if (m_tdata[31:16] !== want.qy)
                        report("quat_y", m_tdata[31:16], want.qy);
                    if (m_tdata[47:32] !== want.qz)
                        report("quat_z", m_tdata[47:32], want.qz);
                    if (m_tdata[62:48] !== want.qw)
                        report("quat_w", 16'(m_tdata[62:48]), 16'(want.qw));
                    if (m_tdata[77:63] !== want.yaw)
                        report("yaw_angle", 16'(m_tdata[77:63]), 16'(want.yaw));
                    if (m_tuser[0] !== want.scaled)
                        report("was_scaled", 16'(m_tuser[0]), 16'(want.scaled));
                    if (m_tuser[1] !== want.bad)
                        report("invalid", 16'(m_tuser[1]), 16'(want.bad));
                end
            end
        end
    end

endmodule

// ===== tb/tb_rotation_vector_to_yaw_core.sv =====
`timescale 1ns / 100ps
// Testbench top for rotation_vector_to_yaw_core: clock, reset, stimulus, back-pressure and
// verdict. Depends on rvy_pkg, the core and tb_rvy_checker.
module tb_rotation_vector_to_yaw_core;

    localparam int IDLE_LIMIT = 4000;   // cycles with no beat moving on either channel
    localparam int PER_PHASE  = 340;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;   // chance of a gap before each input beat
    int          recv_stall_pct = 0;  // chance of holding m_tready low in a cycle
    int          quiet_cycles = 0;

    always #4 clk = ~clk;

    rotation_vector_to_yaw_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // x_half, y_half, z_half
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // quat_x, quat_y, quat_z, quat_w, yaw_angle, zero pad
        .m_tuser  (m_tuser)     // was_scaled, invalid
    );

    tb_rvy_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Stall the output channel at the rate the current phase asks for.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog: end the run when no beat has moved for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("tb_rotation_vector_to_yaw_core NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Draw one half word: mostly magnitudes below one, plus zeros, subnormals,
    // exact ones, large values and the odd infinity or NaN.
    function automatic logic [15:0] pick_half();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            return {1'($urandom), 5'h1F, 10'($urandom)};
        if (sel < 14)
            return {1'($urandom), 5'd0, 10'($urandom)};
        if (sel < 75)
            return {1'($urandom), 5'($urandom_range(0, 14)), 10'($urandom)};
        if (sel < 80)
            return {1'($urandom), 5'd15, 10'd0};
        return {1'($urandom), 5'($urandom_range(0, 30)), 10'($urandom)};
    endfunction

    // Offer one beat from a falling edge and hold it until it is taken.
    task automatic send_sample(input logic [15:0] xh, input logic [15:0] yh,
                               input logic [15:0] zh);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {zh, yh, xh};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PER_PHASE; i++)
        begin
            // keep some samples small enough to stay inside the unit ball
            if ($urandom_range(0, 3) == 0)
                send_sample({1'($urandom), 5'($urandom_range(0, 13)), 10'($urandom)},
                            {1'($urandom), 5'($urandom_range(0, 13)), 10'($urandom)},
                            {1'($urandom), 5'($urandom_range(0, 13)), 10'($urandom)});
            else
                send_sample(pick_half(), pick_half(), pick_half());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero, unit axes, yaw of pi from a unit y, signed zeros,
        // subnormals, largest finite, infinities and NaN, scaled vectors.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h3C00, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h3C00, 16'h0000);
        send_sample(16'h0000, 16'hBC00, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h3C00);
        send_sample(16'h0000, 16'h0000, 16'hBC00);
        send_sample(16'hBC00, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h0001, 16'h03FF, 16'h0400);
        send_sample(16'h8001, 16'h83FF, 16'h8400);
        send_sample(16'h7BFF, 16'h0000, 16'h0000);
        send_sample(16'h7BFF, 16'hFBFF, 16'h7BFF);
        send_sample(16'h3800, 16'h3800, 16'h3800);
        send_sample(16'h3C00, 16'h3C00, 16'h0000);
        send_sample(16'h3A00, 16'hB800, 16'h3400);
        send_sample(16'h7C00, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'hFC00, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7E01);
        send_sample(16'hFFFF, 16'h3C00, 16'h0001);
        send_sample(16'h35A8, 16'h35A8, 16'h0000);

        random_phase(0, 0);
        random_phase(80, 0);
        random_phase(0, 80);
        random_phase(7, 7);

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb_rotation_vector_to_yaw_core OK");
        else
            $display("tb_rotation_vector_to_yaw_core NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rvy_pkg.sv
sv/rvy_front.sv
sv/rvy_isqrt.sv
sv/rvy_div.sv
sv/rvy_yaw.sv
sv/rotation_vector_to_yaw_core.sv
tb/tb_rvy_checker.sv
tb/tb_rotation_vector_to_yaw_core.sv
